// ===== rtl/imu_fp_pkg.sv =====
// imu_fp_pkg: shared types and constants of the imu frame parser
// used by every module under rtl; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package imu_fp_pkg;

   localparam int BYTE_W        = 8;
   localparam int POS_W         = 4;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int AXIS_W        = 16;
   localparam int PAYLOAD_DEPTH = 6;
   localparam int PAYLOAD_IDX_W = 3;
   localparam int FRAME_LEN_DEF = 11;

   localparam logic [POS_W-1:0] PAYLOAD_FIRST = 4'd2;
   localparam logic [POS_W-1:0] PAYLOAD_LAST  = 4'd7;
   localparam logic [POS_W-1:0] POS_AFTER_SYNC = 4'd1;

   localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
   localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
   localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_VALUE = 2'd2;

   localparam logic [AXIS_W-1:0] AXIS_REJECT = 16'h8000;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_SYNC = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] axis_z;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_x;
      logic [STATUS_W-1:0]      status;
      logic [KIND_W-1:0]        frame_kind;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/imu_fp_in_reg.sv =====
// imu_fp_in_reg: input register that holds one received byte for the parser
// depends on imu_fp_pkg
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_in_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [imu_fp_pkg::BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   input  wire                          take,
   output logic                         byte_valid,
   output logic [imu_fp_pkg::BYTE_W-1:0] byte_data
);
   import imu_fp_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;

   assign req_tready = !valid_ff || take;
   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/imu_fp_core.sv =====
// imu_fp_core: header hunt, frame collection, checksum and value check
// depends on imu_fp_pkg
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_core #(
   parameter int FRAME_LEN = imu_fp_pkg::FRAME_LEN_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           byte_valid,
   input  wire  [imu_fp_pkg::BYTE_W-1:0] byte_data,
   output logic                          take,
   output logic                          res_valid,
   input  wire                           res_ready,
   output imu_fp_pkg::result_type        res
);
   import imu_fp_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] payload_ff [PAYLOAD_DEPTH];

   logic                     emit;
   logic                     store;
   logic [PAYLOAD_IDX_W-1:0] store_idx;
   logic [AXIS_W-1:0]        raw_x, raw_y, raw_z;
   logic [STATUS_W-1:0]      status;

   assign raw_x = {payload_ff[1], payload_ff[0]};
   assign raw_y = {payload_ff[3], payload_ff[2]};
   assign raw_z = {payload_ff[5], payload_ff[4]};

   assign emit      = (phase_ff == PH_BODY) && (pos_ff >= LAST_POS);
   assign store     = (phase_ff == PH_BODY) && (pos_ff >= PAYLOAD_FIRST) &&
                      (pos_ff <= PAYLOAD_LAST) && (pos_ff < LAST_POS);
   assign store_idx = PAYLOAD_IDX_W'(pos_ff - PAYLOAD_FIRST);

   assign take      = byte_valid && (!emit || res_ready);
   assign res_valid = byte_valid && emit;

   always_comb begin
      if (sum_ff != byte_data) begin
         status = STATUS_BAD_SUM;
      end else if (raw_x == AXIS_REJECT || raw_y == AXIS_REJECT ||
                   raw_z == AXIS_REJECT) begin
         status = STATUS_BAD_VALUE;
      end else begin
         status = STATUS_OK;
      end
      res.frame_kind = kind_ff;
      res.status     = status;
      res.axis_x     = (status == STATUS_OK) ? raw_x : '0;
      res.axis_y     = (status == STATUS_OK) ? raw_y : '0;
      res.axis_z     = (status == STATUS_OK) ? raw_z : '0;
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      kind_in  = kind_ff;
      unique case (phase_ff)
         PH_SYNC: begin
            if (byte_data >= TYPE_ACCEL && byte_data <= TYPE_ANGLE) begin
               kind_in  = KIND_W'(byte_data - TYPE_ACCEL);
               sum_in   = sum_ff + byte_data;
               pos_in   = PAYLOAD_FIRST;
               phase_in = PH_BODY;
            end else if (byte_data == SYNC_BYTE) begin
               phase_in = PH_SYNC;
               pos_in   = POS_AFTER_SYNC;
               sum_in   = SYNC_BYTE;
            end else begin
               phase_in = PH_HUNT;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
         PH_BODY: begin
            if (!emit) begin
               sum_in = sum_ff + byte_data;
               pos_in = pos_ff + 1'b1;
            end else begin
               phase_in = PH_HUNT;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
         default: begin
            if (byte_data == SYNC_BYTE) begin
               phase_in = PH_SYNC;
               pos_in   = POS_AFTER_SYNC;
               sum_in   = SYNC_BYTE;
            end else begin
               phase_in = PH_HUNT;
               pos_in   = '0;
               sum_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         sum_ff   <= '0;
         kind_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && store) begin
         payload_ff[store_idx] <= byte_data;
      end
   end

   a_body_pos_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (pos_ff >= PAYLOAD_FIRST && pos_ff <= LAST_POS))
      else $error("frame position out of range while collecting");

   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (pos_ff == '0 && sum_ff == '0))
      else $error("position or sum not cleared while hunting");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunting after frame end");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status != STATUS_OK) |->
         (res.axis_x == '0 && res.axis_y == '0 && res.axis_z == '0))
      else $error("values not zeroed on a rejected frame");

endmodule

`default_nettype wire

// ===== rtl/imu_fp_out_reg.sv =====
// imu_fp_out_reg: result register that drives the rsp stream
// depends on imu_fp_pkg
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_out_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          res_valid,
   output logic                         res_ready,
   input  imu_fp_pkg::result_type       res,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [3*imu_fp_pkg::AXIS_W-1:0] rsp_tdata,  // [15:0] axis_x, [31:16] axis_y,
                                                       // [47:32] axis_z
   output logic [imu_fp_pkg::KIND_W+imu_fp_pkg::STATUS_W-1:0] rsp_tuser // [1:0] frame_kind,
                                                                       // [3:2] status
);
   import imu_fp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign res_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.axis_z, data_ff.axis_y, data_ff.axis_x};
   assign rsp_tuser  = {data_ff.status, data_ff.frame_kind};

   always_comb begin
      valid_in = valid_ff;
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         data_ff <= res;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/imu_frame_parser.sv =====
// imu_frame_parser: top level of the imu sensor frame parser
// instantiates imu_fp_in_reg, imu_fp_core and imu_fp_out_reg; depends on imu_fp_pkg
//
// usage:
//   req channel carries one received serial byte per word in req_tdata[7:0]
//   rsp channel carries one word per complete frame: rsp_tuser holds frame_kind
//   and status, rsp_tdata holds axis_x, axis_y and axis_z (raw q15, zero when
//   status is not ok)
//   a frame is sync 0x55, a type byte 0x51..0x53, payload and a sum8 checksum,
//   FRAME_LEN bytes in all
//   throughput: one byte per cycle, sustained, as long as rsp_tready is high
//   the checksum byte passes through the input register, then the result register,
//   before the result word shows on rsp_tvalid
//   reset: synchronous, clears the parser to hunting and empties both registers
//   stall: while a result waits on rsp_tready, bytes that do not end a frame
//   keep flowing; a frame end waits in the input register and req_tready drops
//   only once that register is full and cannot drain
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_parser #(
   parameter int FRAME_LEN = imu_fp_pkg::FRAME_LEN_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [imu_fp_pkg::BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [3*imu_fp_pkg::AXIS_W-1:0] rsp_tdata,  // [15:0] axis_x, [31:16] axis_y,
                                                       // [47:32] axis_z
   output logic [imu_fp_pkg::KIND_W+imu_fp_pkg::STATUS_W-1:0] rsp_tuser // [1:0] frame_kind,
                                                                       // [3:2] status
);
   import imu_fp_pkg::*;

   logic              take;
   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;

   imu_fp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   imu_fp_core #(
      .FRAME_LEN (FRAME_LEN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .take       (take),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   imu_fp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for imu_frame_parser: a directed byte table, checked against
// a list of expected words, then random frames and noise with random idle and stall bursts,
// checked against a frame decoder here; depends on imu_fp_pkg and imu_frame_parser under rtl
`timescale 1ns / 1ps

module tb_top;
   import imu_fp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 600;
   localparam int CALM_BYTES   = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIR_ROWS     = 37;

   localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
   localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RATE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [BYTE_W-1:0]          req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [3*AXIS_W-1:0]        rsp_tdata;
   logic [KIND_W+STATUS_W-1:0] rsp_tuser;

   // frame decoder state
   phase_type         dec_phase;
   logic [POS_W-1:0]  dec_pos;
   logic [BYTE_W-1:0] dec_sum;
   logic [KIND_W-1:0] dec_kind;
   logic [BYTE_W-1:0] dec_payload [PAYLOAD_DEPTH];

   result_type frames_due [$];
   result_type dir_want [$];
   bit         use_dir_want = 1'b1;
   bit         idle_on = 1'b1;
   int         errors = 0;
   int         cycle_count = 0;
   int         sent = 0;
   int         stall_left = 0;

   // repeated sync, bad type, then accel / rate / angle frames
   logic [BYTE_W-1:0] dir_bytes [DIR_ROWS] = '{
      SYNC_BYTE, SYNC_BYTE, 8'h54, SYNC_BYTE,
      SYNC_BYTE, TYPE_ACCEL, 8'hFF, 8'h7F, 8'h01, 8'h80, SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'hFA,
      SYNC_BYTE, TYPE_RATE, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34, 8'h6B,
      SYNC_BYTE, TYPE_ANGLE, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   imu_frame_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic go_hunt();
      dec_phase = PH_HUNT;
      dec_pos   = '0;
      dec_sum   = '0;
   endtask

   task automatic start_header();
      dec_phase = PH_SYNC;
      dec_pos   = POS_AFTER_SYNC;
      dec_sum   = SYNC_BYTE;
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [AXIS_W-1:0] ax, ay, az;
      result_type        res;
      case (dec_phase)
         PH_SYNC: begin
            if (b >= TYPE_ACCEL && b <= TYPE_ANGLE) begin
               dec_kind  = KIND_W'(b - TYPE_ACCEL);
               dec_sum   = dec_sum + b;
               dec_pos   = PAYLOAD_FIRST;
               dec_phase = PH_BODY;
            end else if (b == SYNC_BYTE) begin
               start_header();
            end else begin
               go_hunt();
            end
         end
         PH_BODY: begin
            if (dec_pos < POS_W'(FRAME_LEN_DEF - 1)) begin
               if (dec_pos >= PAYLOAD_FIRST && dec_pos <= PAYLOAD_LAST)
                  dec_payload[dec_pos - PAYLOAD_FIRST] = b;
               dec_sum = dec_sum + b;
               dec_pos = dec_pos + 1'b1;
            end else begin
               ax = {dec_payload[1], dec_payload[0]};
               ay = {dec_payload[3], dec_payload[2]};
               az = {dec_payload[5], dec_payload[4]};
               res = '0;
               res.frame_kind = dec_kind;
               if (dec_sum != b)
                  res.status = STATUS_BAD_SUM;
               else if (ax == AXIS_REJECT || ay == AXIS_REJECT || az == AXIS_REJECT)
                  res.status = STATUS_BAD_VALUE;
               else
                  res.status = STATUS_OK;
               if (res.status == STATUS_OK) begin
                  res.axis_x = ax;
                  res.axis_y = ay;
                  res.axis_z = az;
               end
               if (use_dir_want)
                  frames_due.push_back(dir_want.pop_front());
               else
                  frames_due.push_back(res);
               go_hunt();
            end
         end
         default: begin
            if (b == SYNC_BYTE)
               start_header();
            else
               go_hunt();
         end
      endcase
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b);
      sent++;
   endtask

   function automatic logic [AXIS_W-1:0] pick_axis();
      case ($urandom_range(0, 15))
         0:       pick_axis = AXIS_REJECT;
         1:       pick_axis = 16'h7FFF;
         2:       pick_axis = 16'h8001;
         3:       pick_axis = '0;
         4:       pick_axis = '1;
         default: pick_axis = AXIS_W'($urandom);
      endcase
   endfunction

   task automatic send_frame();
      logic [BYTE_W-1:0] body [FRAME_LEN_DEF];
      logic [BYTE_W-1:0] sum;
      logic [AXIS_W-1:0] v;
      body[0] = SYNC_BYTE;
      body[1] = TYPE_ACCEL + BYTE_W'($urandom_range(0, 2));
      for (int i = 0; i < 3; i++) begin
         v = pick_axis();
         body[2 + 2*i] = v[7:0];
         body[3 + 2*i] = v[15:8];
      end
      for (int i = 8; i < FRAME_LEN_DEF - 1; i++)
         body[i] = BYTE_W'($urandom);
      sum = '0;
      for (int i = 0; i < FRAME_LEN_DEF - 1; i++)
         sum = sum + body[i];
      // mostly good checksums, some corrupted
      if ($urandom_range(0, 5) == 0)
         body[FRAME_LEN_DEF - 1] = sum ^ BYTE_W'($urandom_range(1, 255));
      else
         body[FRAME_LEN_DEF - 1] = sum;
      foreach (body[i]) send_byte(body[i]);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_byte(BYTE_W'($urandom));
         1: send_byte(SYNC_BYTE);
         2: begin
            send_byte(SYNC_BYTE);
            send_byte(BYTE_W'($urandom));
         end
         default: begin
            // truncated frame, misaligns whatever follows
            send_byte(SYNC_BYTE);
            send_byte(TYPE_ACCEL + BYTE_W'($urandom_range(0, 2)));
            repeat ($urandom_range(0, 8)) send_byte(BYTE_W'($urandom));
         end
      endcase
   endtask

   function automatic void check_field(input string name, input logic [AXIS_W-1:0] want,
                                       input logic [AXIS_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result();
      result_type want;
      if (frames_due.size() == 0) begin
         $display("%0t: unexpected word, expected none got tuser %h tdata %h",
                  $time, rsp_tuser, rsp_tdata);
         errors++;
      end else begin
         want = frames_due.pop_front();
         check_field("frame_kind", AXIS_W'(want.frame_kind), AXIS_W'(rsp_tuser[KIND_W-1:0]));
         check_field("status", AXIS_W'(want.status), AXIS_W'(rsp_tuser[KIND_W +: STATUS_W]));
         check_field("axis_x", want.axis_x, rsp_tdata[0 +: AXIS_W]);
         check_field("axis_y", want.axis_y, rsp_tdata[AXIS_W +: AXIS_W]);
         check_field("axis_z", want.axis_z, rsp_tdata[2*AXIS_W +: AXIS_W]);
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         check_result();
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      go_hunt();
      dec_kind = '0;
      foreach (dec_payload[i]) dec_payload[i] = '0;
      dir_want.push_back('{axis_z: 16'sh0055, axis_y: -16'sd32767, axis_x: 16'sd32767,
                           status: STATUS_OK, frame_kind: KIND_ACCEL});
      dir_want.push_back('{axis_z: '0, axis_y: '0, axis_x: '0,
                           status: STATUS_BAD_VALUE, frame_kind: KIND_RATE});
      dir_want.push_back('{axis_z: '0, axis_y: '0, axis_x: '0,
                           status: STATUS_BAD_SUM, frame_kind: KIND_ANGLE});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
      use_dir_want = 1'b0;

      while (sent < DIR_ROWS + RANDOM_BYTES) begin
         idle_on = (sent < DIR_ROWS + RANDOM_BYTES - CALM_BYTES) && $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 3) == 0)
            send_noise();
         else
            send_frame();
      end
      req_tvalid <= 1'b0;

      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
